// ----- src/slcd_pkg.sv -----
// Package for the stroke loop closure detector.
// Holds sizes, the cell control struct, the hit pipeline structs and the state enum.
// No dependencies.
package slcd_pkg;

    localparam int HIST_DEPTH       = 256;
    localparam int COORD_BITS       = 12;
    localparam int PT_W             = 2 * COORD_BITS;
    localparam int CNT_W            = $clog2(HIST_DEPTH + 1);
    localparam int ROT_W            = $clog2(HIST_DEPTH + 4);
    localparam int CFG_W            = 9;
    localparam int MAX_POINTS_RESET = 200;
    localparam int HIT_LAT          = 3;
    localparam int SCAN_END         = HIST_DEPTH + HIT_LAT;
    localparam int DW               = COORD_BITS + 1;
    localparam int PW               = 2 * DW;
    localparam int SW               = PW + 2;

    typedef struct packed {
        logic rot;
        logic ins;
    } t_cell_ctl;

    typedef struct packed {
        logic             valid;
        logic [CNT_W-1:0] k;
        logic [PT_W-1:0]  a0;
        logic [PT_W-1:0]  a1;
        logic [PT_W-1:0]  b0;
        logic [PT_W-1:0]  b1;
    } t_hit_req;

    typedef struct packed {
        logic             valid;
        logic             hit;
        logic [CNT_W-1:0] k;
    } t_hit_rsp;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_UPD  = 3'b100
    } t_state;

endpackage

// ----- src/slcd_in_if.sv -----
// Input channel of the stroke loop closure detector: one stroke point.
// Depends on slcd_pkg.
interface slcd_in_if import slcd_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] point_x;
    logic [COORD_BITS-1:0] point_y;

    modport source (output valid, output point_x, output point_y, input ready);
    modport sink   (input valid, input point_x, input point_y, output ready);
endinterface

// ----- src/slcd_out_if.sv -----
// Output channel of the stroke loop closure detector: one result.
// Depends on slcd_pkg.
interface slcd_out_if import slcd_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             loop_closed;
    logic [CNT_W-1:0] loop_points;
    logic [CNT_W-1:0] history_count;

    modport source (output valid, output loop_closed, output loop_points,
                    output history_count, input ready);
    modport sink   (input valid, input loop_closed, input loop_points,
                    input history_count, output ready);
endinterface

// ----- src/stroke_loop_closure_detector.sv -----
// Stroke loop closure detector top level: ring of history cells,
// hit pipeline and step controller. Depends on slcd_pkg, slcd_cell, slcd_hit.
// With fewer than three held points an accepted input goes straight to the update
// step; otherwise the ring makes one full rotation past the three-stage hit
// pipeline first. A new point is accepted only when idle, after the last update.
// Reset: synchronous active low; history empties, max_points returns to 200.
module stroke_loop_closure_detector import slcd_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_data,
    slcd_in_if.sink          i_pt,
    slcd_out_if.source       o_res
);
    t_state           r_state, n_state;
    logic [CFG_W-1:0] r_max;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_have;
    logic [PT_W-1:0]  r_np, r_prev;
    logic [ROT_W-1:0] r_rot;
    logic             r_hit;
    logic [CNT_W-1:0] r_hitk;
    logic             r_outv, r_loop;
    logic [CNT_W-1:0] r_lpts, r_hcnt;
    logic [CNT_W-1:0] w_limit;
    logic             w_free, w_upd;
    t_cell_ctl        w_ctl;
    t_hit_req         w_req;
    t_hit_rsp         w_rsp;
    logic [PT_W-1:0]  w_pt [HIST_DEPTH];

    for (genvar g = 0; g < HIST_DEPTH; g++) begin : g_cell
        slcd_cell u_cell (
            .i_clk     (i_clk),
            .i_ctl     (w_ctl),
            .i_from_lo ((g == 0) ? r_np : w_pt[(g + HIST_DEPTH - 1) % HIST_DEPTH]),
            .i_from_hi (w_pt[(g + 1) % HIST_DEPTH]),
            .o_pt      (w_pt[g])
        );
    end

    slcd_hit u_hit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    always_comb begin
        if (32'(r_max) < 32'd2) begin
            w_limit = CNT_W'(2);
        end else if (32'(r_max) > 32'(HIST_DEPTH)) begin
            w_limit = CNT_W'(HIST_DEPTH);
        end else begin
            w_limit = CNT_W'(r_max);
        end
    end

    assign w_free    = !r_outv || o_res.ready;
    assign w_upd     = (r_state == S_UPD) && w_free;
    assign w_ctl.rot = (r_state == S_SCAN) && (32'(r_rot) < 32'(HIST_DEPTH));
    assign w_ctl.ins = w_upd;

    assign w_req.valid = w_ctl.rot && (r_rot != '0)
                         && ((32'(r_rot) + 32'd2) <= 32'(r_count));
    assign w_req.k     = CNT_W'(r_rot);
    assign w_req.a0    = r_np;
    assign w_req.a1    = r_prev;
    assign w_req.b0    = w_pt[0];
    assign w_req.b1    = w_pt[1];

    assign i_pt.ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_pt.valid) begin
                    n_state = (r_have && (32'(r_count) >= 32'd3)) ? S_SCAN : S_UPD;
                end
            end
            S_SCAN: begin
                if (32'(r_rot) == 32'(SCAN_END)) begin
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                if (w_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        if (r_hit || !r_have || (r_count == '0)) begin
            n_count = CNT_W'(1);
        end else if ((32'(r_count) + 32'd1) > 32'(w_limit)) begin
            n_count = w_limit;
        end else begin
            n_count = r_count + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_max   <= CFG_W'(MAX_POINTS_RESET);
            r_count <= '0;
            r_have  <= 1'b0;
            r_prev  <= '0;
            r_rot   <= '0;
            r_hit   <= 1'b0;
            r_outv  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_max <= i_cfg_data;
            end
            if (i_pt.valid && i_pt.ready) begin
                r_rot <= '0;
                r_hit <= 1'b0;
            end else if (r_state == S_SCAN) begin
                r_rot <= r_rot + ROT_W'(1);
            end
            if (w_rsp.valid && w_rsp.hit && !r_hit) begin
                r_hit <= 1'b1;
            end
            if (o_res.valid && o_res.ready) begin
                r_outv <= 1'b0;
            end
            if (w_upd) begin
                r_count <= n_count;
                r_have  <= 1'b1;
                r_prev  <= r_np;
                r_outv  <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_pt.valid && i_pt.ready) begin
            r_np <= {i_pt.point_y, i_pt.point_x};
        end
        if (w_rsp.valid && w_rsp.hit && !r_hit) begin
            r_hitk <= w_rsp.k;
        end
        if (w_upd) begin
            r_loop <= r_hit;
            r_lpts <= r_hit ? CNT_W'(32'(r_hitk) + 32'd2) : '0;
            r_hcnt <= n_count;
        end
    end

    assign o_res.valid         = r_outv;
    assign o_res.loop_closed   = r_loop;
    assign o_res.loop_points   = r_lpts;
    assign o_res.history_count = r_hcnt;

    a_have_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_have |-> (r_count != '0))
        else $error("history empty after first point");

    a_rsp_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rsp.valid |-> (r_state == S_SCAN))
        else $error("hit response outside scan");

    a_hit_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.loop_closed) |-> (o_res.history_count == CNT_W'(1)))
        else $error("loop closed without history restart");

    a_upd_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_upd |=> (r_state == S_IDLE) && r_outv)
        else $error("update did not post a result");
endmodule

// ----- src/slcd_cell.sv -----
// One history cell: holds a point, rotates toward its lower neighbor
// or shifts in from its lower neighbor. Depends on slcd_pkg.
module slcd_cell import slcd_pkg::*; (
    input  logic            i_clk,
    input  t_cell_ctl       i_ctl,
    input  logic [PT_W-1:0] i_from_lo,
    input  logic [PT_W-1:0] i_from_hi,
    output logic [PT_W-1:0] o_pt
);
    logic [PT_W-1:0] r_pt;
    logic [PT_W-1:0] n_pt;

    always_comb begin
        n_pt = r_pt;
        if (i_ctl.rot) begin
            n_pt = i_from_hi;
        end else if (i_ctl.ins) begin
            n_pt = i_from_lo;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pt <= n_pt;
    end

    assign o_pt = r_pt;
endmodule

// ----- src/slcd_hit.sv -----
// Pipelined segment intersection test, three stages: differences,
// cross products, compare. Depends on slcd_pkg.
module slcd_hit import slcd_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_hit_req i_req,
    output t_hit_rsp o_rsp
);
    logic signed [DW-1:0] r_s1x, r_s1y, r_s2x, r_s2y, r_dx, r_dy;
    logic signed [PW-1:0] r_p0, r_p1, r_p2, r_p3, r_p4, r_p5;
    logic                 r_v1, r_v2, r_v3, r_hit;
    logic [CNT_W-1:0]     r_k1, r_k2, r_k3;

    function automatic logic signed [DW-1:0] cx(input logic [PT_W-1:0] p);
        return $signed({1'b0, p[COORD_BITS-1:0]});
    endfunction

    function automatic logic signed [DW-1:0] cy(input logic [PT_W-1:0] p);
        return $signed({1'b0, p[PT_W-1:COORD_BITS]});
    endfunction

    logic signed [SW-1:0] w_den, w_sn, w_tn, w_den_n, w_sn_n, w_tn_n;
    logic                 w_hit;

    always_comb begin
        w_den = SW'(r_p0) - SW'(r_p1);
        w_sn  = SW'(r_p2) - SW'(r_p3);
        w_tn  = SW'(r_p4) - SW'(r_p5);
        if (w_den < 0) begin
            w_den_n = -w_den;
            w_sn_n  = -w_sn;
            w_tn_n  = -w_tn;
        end else begin
            w_den_n = w_den;
            w_sn_n  = w_sn;
            w_tn_n  = w_tn;
        end
        w_hit = (w_den != 0) && (w_sn_n >= 0) && (w_sn_n <= w_den_n)
                && (w_tn_n >= 0) && (w_tn_n <= w_den_n);
    end

    always_ff @(posedge i_clk) begin
        r_s1x <= cx(i_req.a1) - cx(i_req.a0);
        r_s1y <= cy(i_req.a1) - cy(i_req.a0);
        r_s2x <= cx(i_req.b1) - cx(i_req.b0);
        r_s2y <= cy(i_req.b1) - cy(i_req.b0);
        r_dx  <= cx(i_req.a0) - cx(i_req.b0);
        r_dy  <= cy(i_req.a0) - cy(i_req.b0);
        r_k1  <= i_req.k;
        r_p0  <= PW'(r_s1x) * PW'(r_s2y);
        r_p1  <= PW'(r_s2x) * PW'(r_s1y);
        r_p2  <= PW'(r_s1x) * PW'(r_dy);
        r_p3  <= PW'(r_s1y) * PW'(r_dx);
        r_p4  <= PW'(r_s2x) * PW'(r_dy);
        r_p5  <= PW'(r_s2y) * PW'(r_dx);
        r_k2  <= r_k1;
        r_hit <= w_hit;
        r_k3  <= r_k2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_req.valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    assign o_rsp.valid = r_v3;
    assign o_rsp.hit   = r_hit;
    assign o_rsp.k     = r_k3;
endmodule
